// ===== sv/lps_pkg.sv =====
// Shared types and constants for the line pixel stepper.
package lps_pkg;

    localparam int COORD_BITS    = 12;
    localparam int ERR_BITS      = COORD_BITS + 3;
    // pointers wrap naturally, so the depth stays a power of two
    localparam int FIFO_DEPTH    = 2;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [ERR_BITS-1:0]   t_err;

    // classified word handed from front to back
    typedef struct packed {
        logic   is_start;
        t_coord cur_x;
        t_coord cur_y;
        t_coord major_end;
        t_err   err;
        t_err   inc_skip;
        t_err   inc_move;
        logic   x_major;
        logic   minor_up;
    } t_work;

endpackage

// ===== sv/line_pixel_stepper.sv =====
// Bresenham line rasterizer: a start word returns the first pixel, each step word the next.
// Start words (cmd 0) carry two signed endpoints; the front end works out the major axis,
// walk direction and error increments and queues the word in a two-entry queue. The back
// end steps one pixel per word with one add on the error term, one increment and one
// compare, and writes the pixel into an output register. Throughput is one word per clock
// and one pixel per clock when pop keeps up; an accepted word is held in the queue, and
// its pixel is written into the output register and shown on the result ports once that
// register is free. A step word with no line in progress (none started, or the last pixel
// already given) returns nothing. A start word drops any line in progress.
module line_pixel_stepper (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  logic            i_cmd,
    input  lps_pkg::t_coord i_start_x,
    input  lps_pkg::t_coord i_start_y,
    input  lps_pkg::t_coord i_end_x,
    input  lps_pkg::t_coord i_end_y,
    output logic            empty,
    input  logic            pop,
    output lps_pkg::t_coord o_pixel_x,
    output lps_pkg::t_coord o_pixel_y,
    output logic            o_last
);
    import lps_pkg::*;

    t_work front_word, queue_word;
    logic  queue_valid, work_take;

    lps_front u_front (
        .i_cmd     (i_cmd),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .o_work    (front_word)
    );

    lps_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_data  (front_word),
        .o_valid (queue_valid),
        .i_pop   (work_take),
        .o_data  (queue_word)
    );

    lps_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (queue_valid),
        .i_work       (queue_word),
        .o_work_take  (work_take),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_last       (o_last)
    );

endmodule

// ===== sv/lps_front.sv =====
// Front end: classifies a word and works out the line setup from the endpoints.
module lps_front (
    input  logic           i_cmd,
    input  lps_pkg::t_coord i_start_x,
    input  lps_pkg::t_coord i_start_y,
    input  lps_pkg::t_coord i_end_x,
    input  lps_pkg::t_coord i_end_y,
    output lps_pkg::t_work  o_work
);
    import lps_pkg::*;

    logic [COORD_BITS:0]   dx_p, dx_n, dy_p, dy_n;
    logic [COORD_BITS-1:0] abs_dx, abs_dy, abs_maj, abs_min;
    logic                  dx_neg, dy_neg, dx_pos, dy_pos;
    logic                  x_major, swap;
    t_err                  maj_e, maj2_e, min2_e;

    // both differences in parallel so the magnitude is a plain select
    assign dx_p = {i_end_x[COORD_BITS-1], i_end_x} - {i_start_x[COORD_BITS-1], i_start_x};
    assign dx_n = {i_start_x[COORD_BITS-1], i_start_x} - {i_end_x[COORD_BITS-1], i_end_x};
    assign dy_p = {i_end_y[COORD_BITS-1], i_end_y} - {i_start_y[COORD_BITS-1], i_start_y};
    assign dy_n = {i_start_y[COORD_BITS-1], i_start_y} - {i_end_y[COORD_BITS-1], i_end_y};

    assign dx_neg = dx_p[COORD_BITS];
    assign dy_neg = dy_p[COORD_BITS];
    assign dx_pos = !dx_neg && (dx_p != '0);
    assign dy_pos = !dy_neg && (dy_p != '0);

    assign abs_dx = dx_neg ? dx_n[COORD_BITS-1:0] : dx_p[COORD_BITS-1:0];
    assign abs_dy = dy_neg ? dy_n[COORD_BITS-1:0] : dy_p[COORD_BITS-1:0];

    assign x_major = (abs_dy <= abs_dx);
    assign abs_maj = x_major ? abs_dx : abs_dy;
    assign abs_min = x_major ? abs_dy : abs_dx;
    // walk from the endpoint with the smaller major coordinate
    assign swap    = x_major ? dx_neg : dy_neg;

    assign maj_e  = {3'b000, abs_maj};
    assign maj2_e = {2'b00, abs_maj, 1'b0};
    assign min2_e = {2'b00, abs_min, 1'b0};

    always_comb begin
        o_work.is_start  = (i_cmd == CMD_START);
        o_work.cur_x     = swap ? i_end_x : i_start_x;
        o_work.cur_y     = swap ? i_end_y : i_start_y;
        if (x_major) begin
            o_work.major_end = swap ? i_start_x : i_end_x;
        end else begin
            o_work.major_end = swap ? i_start_y : i_end_y;
        end
        o_work.err       = min2_e - maj_e;
        o_work.inc_skip  = min2_e;
        o_work.inc_move  = min2_e - maj2_e;
        o_work.x_major   = x_major;
        o_work.minor_up  = (dx_neg && dy_neg) || (dx_pos && dy_pos);
    end

endmodule

// ===== sv/lps_fifo.sv =====
// Short queue of classified words between front and back.
module lps_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  lps_pkg::t_work i_data,
    output logic           o_valid,
    input  logic           i_pop,
    output lps_pkg::t_work o_data
);
    import lps_pkg::*;

    t_work                    r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [FIFO_CNT_BITS-1:0] r_cnt, n_cnt;
    logic                     do_push, do_pop;

    assign o_full  = (r_cnt == FIFO_CNT_BITS'(FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = do_push ? r_wr + 1'b1 : r_wr;
        n_rd  = do_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== sv/lps_back.sv =====
// Back end: holds the line state, steps one pixel per word, owns the result register.
module lps_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_work_valid,
    input  lps_pkg::t_work  i_work,
    output logic            o_work_take,
    output logic            o_empty,
    input  logic            i_pop,
    output lps_pkg::t_coord o_pixel_x,
    output lps_pkg::t_coord o_pixel_y,
    output logic            o_last
);
    import lps_pkg::*;

    logic   r_active, n_active;
    logic   r_out_valid, n_out_valid;
    t_coord r_cur_x, r_cur_y, r_major_end;
    t_coord n_cur_x, n_cur_y, n_major_end;
    t_err   r_err, r_inc_skip, r_inc_move;
    t_err   n_err, n_inc_skip, n_inc_move;
    logic   r_x_major, r_minor_up, n_x_major, n_minor_up;
    t_coord r_out_x, r_out_y, n_out_x, n_out_y;
    logic   r_out_last, n_out_last;

    logic   slot_free, move, produce;
    t_coord minor_d, step_x, step_y, step_major, start_major;
    t_err   step_err;
    logic   step_last, start_last;

    assign slot_free   = !r_out_valid || i_pop;
    assign o_work_take = i_work_valid && slot_free;

    // x-major moves on err >= 0, y-major only on err > 0
    assign move = r_x_major ? !r_err[ERR_BITS-1]
                            : (!r_err[ERR_BITS-1] && (r_err != '0));
    assign minor_d = r_minor_up ? t_coord'(1) : t_coord'(-1);

    always_comb begin
        if (r_x_major) begin
            step_x = r_cur_x + t_coord'(1);
            step_y = move ? r_cur_y + minor_d : r_cur_y;
        end else begin
            step_x = move ? r_cur_x + minor_d : r_cur_x;
            step_y = r_cur_y + t_coord'(1);
        end
    end

    assign step_err    = r_err + (move ? r_inc_move : r_inc_skip);
    // major coordinate only climbs toward the end, so equality marks the end
    assign step_major  = r_x_major ? step_x : step_y;
    assign step_last   = (step_major == r_major_end);
    assign start_major = i_work.x_major ? i_work.cur_x : i_work.cur_y;
    assign start_last  = (start_major == i_work.major_end);

    always_comb begin
        n_active    = r_active;
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_major_end = r_major_end;
        n_err       = r_err;
        n_inc_skip  = r_inc_skip;
        n_inc_move  = r_inc_move;
        n_x_major   = r_x_major;
        n_minor_up  = r_minor_up;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_last  = r_out_last;
        produce     = 1'b0;
        if (o_work_take) begin
            if (i_work.is_start) begin
                produce     = 1'b1;
                n_cur_x     = i_work.cur_x;
                n_cur_y     = i_work.cur_y;
                n_major_end = i_work.major_end;
                n_err       = i_work.err;
                n_inc_skip  = i_work.inc_skip;
                n_inc_move  = i_work.inc_move;
                n_x_major   = i_work.x_major;
                n_minor_up  = i_work.minor_up;
                n_active    = !start_last;
                n_out_x     = i_work.cur_x;
                n_out_y     = i_work.cur_y;
                n_out_last  = start_last;
            end else if (r_active) begin
                produce    = 1'b1;
                n_cur_x    = step_x;
                n_cur_y    = step_y;
                n_err      = step_err;
                n_active   = !step_last;
                n_out_x    = step_x;
                n_out_y    = step_y;
                n_out_last = step_last;
            end
        end
        if (produce) begin
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_x     <= n_cur_x;
        r_cur_y     <= n_cur_y;
        r_major_end <= n_major_end;
        r_err       <= n_err;
        r_inc_skip  <= n_inc_skip;
        r_inc_move  <= n_inc_move;
        r_x_major   <= n_x_major;
        r_minor_up  <= n_minor_up;
        r_out_x     <= n_out_x;
        r_out_y     <= n_out_y;
        r_out_last  <= n_out_last;
    end

    assign o_empty   = !r_out_valid;
    assign o_pixel_x = r_out_x;
    assign o_pixel_y = r_out_y;
    assign o_last    = r_out_last;

endmodule

// ===== test/tb_line_pixel_stepper.sv =====
// Self-checking testbench for line_pixel_stepper: result ports against a queue of predicted pixels.
module tb_line_pixel_stepper;
    import lps_pkg::*;

    typedef struct {
        t_coord px;
        t_coord py;
        logic   last;
    } t_pixel;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   push = 1'b0;
    logic   full;
    logic   i_cmd = CMD_STEP;
    t_coord i_start_x = '0;
    t_coord i_start_y = '0;
    t_coord i_end_x = '0;
    t_coord i_end_y = '0;
    logic   empty;
    logic   pop = 1'b0;
    t_coord o_pixel_x;
    t_coord o_pixel_y;
    logic   o_last;

    // line walker state, mirrors the block
    logic                  line_on = 1'b0;
    t_coord                walk_x = '0;
    t_coord                walk_y = '0;
    t_coord                major_stop = '0;
    logic [COORD_BITS-1:0] span_x = '0;
    logic [COORD_BITS-1:0] span_y = '0;
    t_err                  decision = '0;
    logic                  walk_x_major = 1'b0;
    logic                  walk_minor_up = 1'b0;

    t_pixel pixel_q[$];
    int     pixel_words = 0;
    int     fail_count = 0;
    int     send_idle_pct = 12;
    int     pop_idle_pct = 12;
    int     hold_cycles = 0;

    line_pixel_stepper i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_cmd     (i_cmd),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .empty     (empty),
        .pop       (pop),
        .o_pixel_x (o_pixel_x),
        .o_pixel_y (o_pixel_y),
        .o_last    (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #(12 * 200000);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void queue_current_pixel();
        t_coord major;
        t_pixel pix;
        major = walk_x_major ? walk_x : walk_y;
        pix.px = walk_x;
        pix.py = walk_y;
        pix.last = (major >= major_stop);
        line_on = !pix.last;
        pixel_q.push_back(pix);
        pixel_words++;
    endfunction

    function automatic void walk_line(logic cmd, t_coord sx, t_coord sy, t_coord ex, t_coord ey);
        int dx;
        int dy;
        if (cmd == CMD_START) begin
            dx = int'(ex) - int'(sx);
            dy = int'(ey) - int'(sy);
            span_x = COORD_BITS'((dx < 0) ? -dx : dx);
            span_y = COORD_BITS'((dy < 0) ? -dy : dy);
            walk_minor_up = (dx < 0 && dy < 0) || (dx > 0 && dy > 0);
            walk_x_major = (span_y <= span_x);
            if (walk_x_major) begin
                decision = t_err'(2 * int'(span_y) - int'(span_x));
                if (dx >= 0) begin
                    walk_x = sx; walk_y = sy; major_stop = ex;
                end else begin
                    walk_x = ex; walk_y = ey; major_stop = sx;
                end
            end else begin
                decision = t_err'(2 * int'(span_x) - int'(span_y));
                if (dy >= 0) begin
                    walk_x = sx; walk_y = sy; major_stop = ey;
                end else begin
                    walk_x = ex; walk_y = ey; major_stop = sy;
                end
            end
            queue_current_pixel();
        end else if (line_on) begin
            if (walk_x_major) begin
                walk_x = walk_x + t_coord'(1);
                if (decision < 0) begin
                    decision = t_err'(int'(decision) + 2 * int'(span_y));
                end else begin
                    walk_y = walk_minor_up ? walk_y + t_coord'(1) : walk_y - t_coord'(1);
                    decision = t_err'(int'(decision) + 2 * (int'(span_y) - int'(span_x)));
                end
            end else begin
                walk_y = walk_y + t_coord'(1);
                // y-major skips on zero as well
                if (decision <= 0) begin
                    decision = t_err'(int'(decision) + 2 * int'(span_x));
                end else begin
                    walk_x = walk_minor_up ? walk_x + t_coord'(1) : walk_x - t_coord'(1);
                    decision = t_err'(int'(decision) + 2 * (int'(span_x) - int'(span_y)));
                end
            end
            queue_current_pixel();
        end
    endfunction

    // push stays high on return so back-to-back words need no re-raise
    task automatic send_word(input logic cmd, input t_coord sx, input t_coord sy,
                             input t_coord ex, input t_coord ey);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_cmd     <= cmd;
        i_start_x <= sx;
        i_start_y <= sy;
        i_end_x   <= ex;
        i_end_y   <= ey;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        walk_line(cmd, sx, sy, ex, ey);
    endtask

    // step words carry junk endpoints, which must be ignored
    task automatic send_steps(input int count);
        repeat (count) send_word(CMD_STEP, t_coord'($urandom), t_coord'($urandom),
                                 t_coord'($urandom), t_coord'($urandom));
    endtask

    task automatic send_line(input t_coord sx, input t_coord sy, input t_coord ex,
                             input t_coord ey, input int steps);
        send_word(CMD_START, sx, sy, ex, ey);
        send_steps(steps);
    endtask

    function automatic t_coord coord_near(t_coord base, int reach);
        int v;
        v = int'(base) + int'($urandom_range(2 * reach)) - reach;
        if (v > 2047) v = 2047;
        if (v < -2048) v = -2048;
        return t_coord'(v);
    endfunction

    function automatic int line_length(t_coord sx, t_coord sy, t_coord ex, t_coord ey);
        int dx;
        int dy;
        dx = int'(ex) - int'(sx);
        dy = int'(ey) - int'(sy);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return (dx > dy) ? dx : dy;
    endfunction

    task automatic test_directed();
        send_steps(1);                                  // nothing started yet
        send_line(12'sd0, 12'sd0, 12'sd0, 12'sd0, 1);   // single point, then step past it
        send_line(-12'sd2048, -12'sd2048, -12'sd2048, -12'sd2048, 0);
        send_line(12'sd2047, 12'sd2047, 12'sd2047, 12'sd2047, 0);
        send_line(12'sd0, 12'sd0, 12'sd2, 12'sd1, 3);   // x-major, error starts at zero
        send_line(12'sd0, 12'sd0, 12'sd1, 12'sd2, 2);   // y-major, error starts at zero
        send_line(12'sd4, 12'sd6, 12'sd4, 12'sd3, 3);   // vertical, walked from the low end
        send_line(12'sd3, -12'sd1, 12'sd0, 12'sd2, 1);  // diagonal, minor goes down
        // full-range lines, each dropped early by the next start
        send_line(-12'sd2048, 12'sd2047, 12'sd2047, -12'sd2048, 1);
        send_line(12'sd2047, -12'sd2048, -12'sd2048, -12'sd2048, 1);
        send_line(12'sd5, 12'sd5, 12'sd2, 12'sd4, 3);
    endtask

    task automatic test_random_lines(input int pixel_goal);
        int     goal;
        int     len;
        int     steps;
        t_coord sx;
        t_coord sy;
        t_coord ex;
        t_coord ey;
        goal = pixel_words + pixel_goal;
        while (pixel_words < goal) begin
            if ($urandom_range(99) < 10) begin
                // noise: any endpoints, a few steps, stray steps
                sx = t_coord'($urandom); sy = t_coord'($urandom);
                ex = t_coord'($urandom); ey = t_coord'($urandom);
                send_line(sx, sy, ex, ey, $urandom_range(4));
            end else if ($urandom_range(99) < 5) begin
                send_steps(1 + $urandom_range(2));
            end else begin
                sx = t_coord'($urandom);
                sy = t_coord'($urandom);
                ex = coord_near(sx, 1 + $urandom_range(15));
                ey = coord_near(sy, 1 + $urandom_range(15));
                len = line_length(sx, sy, ex, ey);
                if ($urandom_range(99) < 70)
                    steps = len + $urandom_range(1);
                else
                    steps = $urandom_range(len + 2);
                send_line(sx, sy, ex, ey, steps);
            end
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        hold_cycles = 80;
        send_line(12'sd0, 12'sd0, 12'sd60, 12'sd10, 60);
        send_idle_pct = 12;
    endtask

    task automatic test_streaming(input int pixel_goal);
        send_idle_pct = 0;
        pop_idle_pct = 0;
        test_random_lines(pixel_goal);
        send_idle_pct = 12;
        pop_idle_pct = 12;
    endtask

    initial begin : pixel_checker
        t_pixel want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                if (pixel_q.size() == 0) begin
                    $error("unexpected pixel (%0d,%0d) last=%0b", o_pixel_x, o_pixel_y, o_last);
                    fail_count++;
                end else begin
                    want = pixel_q.pop_front();
                    if (o_pixel_x !== want.px) begin
                        $error("pixel_x: expected %0d, got %0d", want.px, o_pixel_x);
                        fail_count++;
                    end
                    if (o_pixel_y !== want.py) begin
                        $error("pixel_y: expected %0d, got %0d", want.py, o_pixel_y);
                        fail_count++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, o_last);
                        fail_count++;
                    end
                end
            end
            if (hold_cycles > 0) begin
                pop <= 1'b0;
                hold_cycles--;
            end else begin
                pop <= ($urandom_range(99) >= pop_idle_pct);
            end
        end
    end

    initial begin : main
        int wait_cycles;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_lines(420);
        test_backpressure();
        test_streaming(100);

        push <= 1'b0;
        for (wait_cycles = 0; pixel_q.size() != 0 && wait_cycles < 5000; wait_cycles++)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (pixel_q.size() != 0) begin
            $error("%0d expected pixels never arrived", pixel_q.size());
            fail_count++;
        end

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
